/* hw/rtl/rsf_pkg.sv */
// Package for the rectangle fragment block: fragment and job types, queue depth,
// and a helper for the positive-size test.
// No dependencies.
`default_nettype none

package rsf_pkg;

  localparam int unsigned CoordW     = 16;
  localparam int unsigned SizeW      = 15;
  localparam int unsigned NumFrags   = 4;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [SizeW-1:0]  h;
    logic [SizeW-1:0]  w;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } frag_t;

  typedef struct packed {
    logic [NumFrags-1:0]           mask;
    frag_t [NumFrags-1:0]          frags;
  } job_t;

  function automatic logic pos16(logic [CoordW-1:0] v);
    return !v[CoordW-1] && (v != '0);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rsf_front.sv */
// Front part: takes input words, works out the edges, the overlap and all four
// candidate fragments in a two-stage pipeline, and pushes non-empty jobs.
// Depends on rsf_pkg.
`default_nettype none

module rsf_front
  import rsf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               old_present_i,
  input  wire logic [CoordW-1:0]  old_x_i,
  input  wire logic [CoordW-1:0]  old_y_i,
  input  wire logic [CoordW-1:0]  old_w_i,
  input  wire logic [CoordW-1:0]  old_h_i,
  input  wire logic               new_present_i,
  input  wire logic [CoordW-1:0]  new_x_i,
  input  wire logic [CoordW-1:0]  new_y_i,
  input  wire logic [CoordW-1:0]  new_w_i,
  input  wire logic [CoordW-1:0]  new_h_i,
  output logic                    job_valid_o,
  input  wire logic               job_ready_i,
  output job_t                    job_o
);

  localparam logic [CoordW-1:0] One = CoordW'(1);

  logic s1_valid_q, s1_valid_d;
  logic s2_valid_q, s2_valid_d;
  logic s1_ready, s2_ready;

  logic [CoordW-1:0] s1_ox_q, s1_oy_q, s1_ow_q, s1_oh_q, s1_nx_q, s1_ny_q;
  logic [CoordW-1:0] s1_oright_q, s1_obottom_q, s1_nright_q, s1_nbottom_q;
  logic              s1_old_ok_q, s1_new_ok_q;

  logic [CoordW-1:0] s2_ox_q, s2_oy_q, s2_ow_q, s2_oh_q;
  logic [CoordW-1:0] s2_ax0_q, s2_ay0_q, s2_ax1_q, s2_ay1_q;
  logic [CoordW-1:0] s2_top_h_q, s2_bot_y_q, s2_bot_h_q;
  logic [CoordW-1:0] s2_left_w_q, s2_right_x_q, s2_right_w_q;
  logic              s2_top_q, s2_bot_q, s2_left_q, s2_right_q;
  logic              s2_old_ok_q, s2_new_ok_q;

  logic              disjoint;
  logic [CoordW-1:0] mid_h;
  job_t              job;

  assign s2_ready    = !s2_valid_q || job_ready_i || (job.mask == '0);
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign in_ready_o  = s1_ready;
  assign s1_valid_d  = s1_ready ? in_valid_i : s1_valid_q;
  assign s2_valid_d  = s2_ready ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_ox_q      <= old_x_i;
      s1_oy_q      <= old_y_i;
      s1_ow_q      <= old_w_i;
      s1_oh_q      <= old_h_i;
      s1_nx_q      <= new_x_i;
      s1_ny_q      <= new_y_i;
      s1_oright_q  <= old_x_i + old_w_i - One;
      s1_obottom_q <= old_y_i + old_h_i - One;
      s1_nright_q  <= new_x_i + new_w_i - One;
      s1_nbottom_q <= new_y_i + new_h_i - One;
      s1_old_ok_q  <= old_present_i && pos16(old_w_i) && pos16(old_h_i);
      s1_new_ok_q  <= new_present_i && pos16(new_w_i) && pos16(new_h_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_ox_q      <= s1_ox_q;
      s2_oy_q      <= s1_oy_q;
      s2_ow_q      <= s1_ow_q;
      s2_oh_q      <= s1_oh_q;
      s2_ax0_q     <= ($signed(s1_nx_q) > $signed(s1_ox_q)) ? s1_nx_q : s1_ox_q;
      s2_ay0_q     <= ($signed(s1_ny_q) > $signed(s1_oy_q)) ? s1_ny_q : s1_oy_q;
      s2_ax1_q     <= ($signed(s1_nright_q) < $signed(s1_oright_q)) ?
                      s1_nright_q : s1_oright_q;
      s2_ay1_q     <= ($signed(s1_nbottom_q) < $signed(s1_obottom_q)) ?
                      s1_nbottom_q : s1_obottom_q;
      s2_top_q     <= $signed(s1_ny_q) > $signed(s1_oy_q);
      s2_bot_q     <= $signed(s1_nbottom_q) < $signed(s1_obottom_q);
      s2_left_q    <= $signed(s1_nx_q) > $signed(s1_ox_q);
      s2_right_q   <= $signed(s1_nright_q) < $signed(s1_oright_q);
      s2_top_h_q   <= s1_ny_q - s1_oy_q;
      s2_bot_y_q   <= s1_nbottom_q + One;
      s2_bot_h_q   <= s1_obottom_q - s1_nbottom_q;
      s2_left_w_q  <= s1_nx_q - s1_ox_q;
      s2_right_x_q <= s1_nright_q + One;
      s2_right_w_q <= s1_oright_q - s1_nright_q;
      s2_old_ok_q  <= s1_old_ok_q;
      s2_new_ok_q  <= s1_new_ok_q;
    end
  end

  assign disjoint = ($signed(s2_ax0_q) > $signed(s2_ax1_q)) ||
                    ($signed(s2_ay0_q) > $signed(s2_ay1_q));
  assign mid_h    = s2_ay1_q - s2_ay0_q + One;

  always_comb begin
    job.frags[0] = '{x: s2_ox_q, y: s2_oy_q, w: s2_ow_q[SizeW-1:0], h: s2_oh_q[SizeW-1:0]};
    job.frags[1] = '{x: s2_ox_q, y: s2_bot_y_q, w: s2_ow_q[SizeW-1:0],
                     h: s2_bot_h_q[SizeW-1:0]};
    job.frags[2] = '{x: s2_ox_q, y: s2_ay0_q, w: s2_left_w_q[SizeW-1:0],
                     h: mid_h[SizeW-1:0]};
    job.frags[3] = '{x: s2_right_x_q, y: s2_ay0_q, w: s2_right_w_q[SizeW-1:0],
                     h: mid_h[SizeW-1:0]};
    job.mask     = '0;
    if (!s2_old_ok_q) begin
      job.mask = '0;
    end else if (!s2_new_ok_q || disjoint) begin
      job.mask = 4'b0001;
    end else begin
      job.frags[0].h = s2_top_h_q[SizeW-1:0];
      job.mask[0]    = s2_top_q && pos16(s2_top_h_q);
      job.mask[1]    = s2_bot_q && pos16(s2_bot_h_q);
      job.mask[2]    = s2_left_q && pos16(s2_left_w_q) && pos16(mid_h);
      job.mask[3]    = s2_right_q && pos16(s2_right_w_q) && pos16(mid_h);
    end
  end

  assign job_valid_o = s2_valid_q && (job.mask != '0);
  assign job_o       = job;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> s2_old_ok_q)
    else $error("Job pushed for an absent or empty old rectangle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_ready) |=> (s2_valid_q && $stable(job.mask)))
    else $error("Stalled job changed in the front pipeline.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_o && (!s2_new_ok_q || disjoint)) |-> (job.mask == 4'b0001))
    else $error("Whole-rectangle job carries more than one fragment.");

endmodule

`default_nettype wire

/* hw/rtl/rsf_queue.sv */
// Short job queue between the front and back parts.
// Depends on rsf_pkg.
`default_nettype none

module rsf_queue
  import rsf_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire job_t  push_job_i,
  output logic       pop_valid_o,
  input  wire logic  pop_i,
  output job_t       pop_job_o
);

  job_t                  mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  count_q, count_d;
  logic                  do_push, do_pop;

  assign push_ready_o = count_q != QueueCntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_job_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntW'(QueueDepth))
    else $error("Job queue count exceeds its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("Job queue count missed a push.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("Job queue count missed a pop.");

endmodule

`default_nettype wire

/* hw/rtl/rsf_back.sv */
// Back part, depends on rsf_pkg: walks the fragment mask of the head job and
// sends one fragment word per cycle unless stalled, from an output register.
`default_nettype none

module rsf_back
  import rsf_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  job_valid_i,
  input  wire job_t  job_i,
  output logic       job_pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output frag_t      out_frag_o,
  output logic       out_last_o
);

  logic [NumFrags-1:0] done_q, done_d;
  logic [NumFrags-1:0] remaining, sel;
  logic                last, load;
  logic                out_valid_q, out_valid_d;
  logic                out_last_q;
  frag_t               out_frag_q, pick;

  assign remaining = job_i.mask & ~done_q;
  assign sel       = remaining & (~remaining + 1'b1);
  assign last      = (remaining & ~sel) == '0;
  assign load      = job_valid_i && (!out_valid_q || out_ready_i);
  assign job_pop_o = load && last;

  always_comb begin
    pick = job_i.frags[0];
    for (int i = 0; i < NumFrags; i++) begin
      if (sel[i]) begin
        pick = job_i.frags[i];
      end
    end
  end

  always_comb begin
    done_d      = done_q;
    out_valid_d = out_valid_q;
    if (load) begin
      done_d      = last ? '0 : (done_q | sel);
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_frag_q <= pick;
      out_last_q <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_frag_o  = out_frag_q;
  assign out_last_o  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> (remaining != '0))
    else $error("Head job has no fragment left to send.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> $onehot(sel))
    else $error("Fragment select is not one-hot.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_frag_q.w != '0) && (out_frag_q.h != '0)))
    else $error("Fragment word with zero size.");

endmodule

`default_nettype wire

/* hw/rtl/rect_subtract_fragments.sv */
// Top level of the rectangle difference block: front pipeline, job queue and
// fragment sender. Depends on rsf_pkg, rsf_front, rsf_queue and rsf_back.
//
// Each input word holds an old and a new rectangle; the block answers with the
// parts of the old one that the new one leaves uncovered (top band, bottom
// band, left strip, right strip), one fragment word per cycle while the output
// is not held off, tlast on the last fragment of each input. Inputs that give
// no fragment produce no word. The front takes one input word per cycle, unless
// its pipeline is stalled, through a two-stage pipeline into a two-entry job
// queue; the fragment sender then sends the one to four fragments of an input
// as separate words. The first fragment word of an input passes through the
// two front stages, the job queue and the output register.
`default_nettype none

module rect_subtract_fragments
  import rsf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // old_present, old_x, old_y, old_w, old_h, new_present, new_x, new_y,
  // new_w, new_h, zero padding
  input  wire logic [135:0] s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // frag_x, frag_y, frag_w, frag_h, zero padding
  output logic [63:0]       m_axis_tdata_o,
  // frag_last
  output logic              m_axis_tlast_o
);

  logic  job_valid, job_ready, q_valid, q_pop;
  job_t  push_job, head_job;
  frag_t out_frag;

  rsf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .old_present_i (s_axis_tdata_i[0]),
    .old_x_i       (s_axis_tdata_i[16:1]),
    .old_y_i       (s_axis_tdata_i[32:17]),
    .old_w_i       (s_axis_tdata_i[48:33]),
    .old_h_i       (s_axis_tdata_i[64:49]),
    .new_present_i (s_axis_tdata_i[65]),
    .new_x_i       (s_axis_tdata_i[81:66]),
    .new_y_i       (s_axis_tdata_i[97:82]),
    .new_w_i       (s_axis_tdata_i[113:98]),
    .new_h_i       (s_axis_tdata_i[129:114]),
    .job_valid_o   (job_valid),
    .job_ready_i   (job_ready),
    .job_o         (push_job)
  );

  rsf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_job_o    (head_job)
  );

  rsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .job_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_frag_o  (out_frag),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, out_frag};

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for rect_subtract_fragments: random and directed rectangle pairs
// are streamed in, every fragment word is checked against a behavioral predictor.
// Depends on rsf_pkg and the rect_subtract_fragments RTL.
`timescale 1ns / 100ps

module testbench;
  import rsf_pkg::*;

  localparam int StallLimit = 4000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic [15:0] new_h;
    logic [15:0] new_w;
    logic [15:0] new_y;
    logic [15:0] new_x;
    logic        new_present;
    logic [15:0] old_h;
    logic [15:0] old_w;
    logic [15:0] old_y;
    logic [15:0] old_x;
    logic        old_present;
  } rect_pair_t;

  typedef struct packed {
    frag_t frag;
    logic  last;
  } frag_word_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic [135:0] s_data = '0;
  logic         s_ready;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [63:0]  m_data;
  logic         m_last;

  rect_pair_t pair_queue[$];
  frag_word_t expected_frags[$];
  int         err_cnt = 0;
  int         cyc = 0;
  int         idle_cycles = 0;
  int         pairs_taken = 0;
  int         send_gap = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  bit         in_taken = 1'b0;

  rect_subtract_fragments dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int wrap16(int v);
    return int'(shortint'(v));
  endfunction

  function automatic void add_frag(int x, int y, int w, int h);
    frag_word_t fw;
    if (w <= 0 || h <= 0) begin
      return;
    end
    fw.frag.x = 16'(x);
    fw.frag.y = 16'(y);
    fw.frag.w = 15'(w);
    fw.frag.h = 15'(h);
    fw.last   = 1'b0;
    expected_frags.push_back(fw);
  endfunction

  // Old rectangle minus new one: top band, bottom band, left strip, right strip.
  function automatic void subtract_rects(rect_pair_t p);
    int ox, oy, ow, oh, nx, ny, nw, nh;
    int oright, obottom, nright, nbottom;
    int ax0, ay0, ax1, ay1;
    int first;
    first = expected_frags.size();
    ox = $signed(p.old_x);
    oy = $signed(p.old_y);
    ow = $signed(p.old_w);
    oh = $signed(p.old_h);
    nx = $signed(p.new_x);
    ny = $signed(p.new_y);
    nw = $signed(p.new_w);
    nh = $signed(p.new_h);
    if (!p.old_present || ow <= 0 || oh <= 0) begin
      return;
    end
    if (!p.new_present || nw <= 0 || nh <= 0) begin
      add_frag(ox, oy, ow, oh);
    end else begin
      oright  = wrap16(ox + ow - 1);
      obottom = wrap16(oy + oh - 1);
      nright  = wrap16(nx + nw - 1);
      nbottom = wrap16(ny + nh - 1);
      ax0 = (ox > nx) ? ox : nx;
      ay0 = (oy > ny) ? oy : ny;
      ax1 = (oright < nright) ? oright : nright;
      ay1 = (obottom < nbottom) ? obottom : nbottom;
      if (ax0 > ax1 || ay0 > ay1) begin
        add_frag(ox, oy, ow, oh);
      end else begin
        if (oy < ay0) begin
          add_frag(ox, oy, ow, wrap16(ay0 - oy));
        end
        if (ay1 < obottom) begin
          add_frag(ox, wrap16(ay1 + 1), ow, wrap16(obottom - ay1));
        end
        if (ox < ax0) begin
          add_frag(ox, ay0, wrap16(ax0 - ox), wrap16(ay1 - ay0 + 1));
        end
        if (ax1 < oright) begin
          add_frag(wrap16(ax1 + 1), ay0, wrap16(oright - ax1), wrap16(ay1 - ay0 + 1));
        end
      end
    end
    if (expected_frags.size() > first) begin
      expected_frags[expected_frags.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic check_fragment(frag_t got, logic got_last);
    frag_word_t want;
    if (expected_frags.size() == 0) begin
      $error("unexpected fragment word: x=%0d y=%0d w=%0d h=%0d",
             $signed(got.x), $signed(got.y), got.w, got.h);
      err_cnt++;
      return;
    end
    want = expected_frags.pop_front();
    if (got.x !== want.frag.x) begin
      $error("frag_x: expected %0d, got %0d", $signed(want.frag.x), $signed(got.x));
      err_cnt++;
    end
    if (got.y !== want.frag.y) begin
      $error("frag_y: expected %0d, got %0d", $signed(want.frag.y), $signed(got.y));
      err_cnt++;
    end
    if (got.w !== want.frag.w) begin
      $error("frag_w: expected %0d, got %0d", want.frag.w, got.w);
      err_cnt++;
    end
    if (got.h !== want.frag.h) begin
      $error("frag_h: expected %0d, got %0d", want.frag.h, got.h);
      err_cnt++;
    end
    if (got_last !== want.last) begin
      $error("frag_last: expected %0b, got %0b", want.last, got_last);
      err_cnt++;
    end
  endtask

  task automatic queue_pair(bit op, int ox, int oy, int ow, int oh,
                            bit np, int nx, int ny, int nw, int nh);
    rect_pair_t p;
    p.old_present = op;
    p.old_x       = 16'(ox);
    p.old_y       = 16'(oy);
    p.old_w       = 16'(ow);
    p.old_h       = 16'(oh);
    p.new_present = np;
    p.new_x       = 16'(nx);
    p.new_y       = 16'(ny);
    p.new_w       = 16'(nw);
    p.new_h       = 16'(nh);
    pair_queue.push_back(p);
  endtask

  // Mostly short gaps, a few long ones, and none at all in every fourth stretch.
  function automatic int pick_gap();
    int r;
    if (((cyc / 256) % 4) == 0) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return -$urandom_range(0, 3);
    end else if (r == 1) begin
      return $urandom_range(1, 32767);
    end
    return $urandom_range(1, 48);
  endfunction

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        check_fragment(frag_t'(m_data[61:0]), m_last);
      end
      if (s_valid && s_ready) begin
        subtract_rects(rect_pair_t'(s_data[129:0]));
        pairs_taken <= pairs_taken + 1;
      end
      in_taken <= s_valid && s_ready;
      if ((m_valid && m_ready) || (s_valid && s_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_valid || in_taken)) begin
      if (send_gap > 0 || pair_queue.size() == 0) begin
        s_valid <= 1'b0;
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end
      end else begin
        s_data   <= {6'b0, pair_queue.pop_front()};
        s_valid  <= 1'b1;
        send_gap <= pick_gap();
      end
    end
  end

  // The receiver also holds off once for a long stretch so that the block backs up.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && pairs_taken >= 150) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        m_ready   <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_ready   <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_ready    <= 1'b0;
      end else begin
        m_ready    <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  initial begin
    int r, ox, oy;
    // Directed pairs: empty and absent rectangles, disjoint, covered and partial overlaps.
    queue_pair(0, 10, 10, 20, 20, 1, 15, 15, 4, 4);
    queue_pair(1, 10, 10, 0, 20, 1, 15, 15, 4, 4);
    queue_pair(1, 10, 10, 20, -5, 1, 15, 15, 4, 4);
    queue_pair(1, 10, 10, -32768, 20, 1, 15, 15, 4, 4);
    queue_pair(1, -100, 50, 30, 40, 0, 0, 0, 5, 5);
    queue_pair(1, -100, 50, 30, 40, 1, -90, 60, 0, 5);
    queue_pair(1, -100, 50, 30, 40, 1, -90, 60, 5, -32768);
    queue_pair(1, 0, 0, 10, 10, 1, 10, 0, 10, 10);
    queue_pair(1, 0, 0, 10, 10, 1, 0, -20, 10, 20);
    queue_pair(1, 5, 5, 10, 10, 1, 0, 0, 40, 40);
    queue_pair(1, 5, 5, 10, 10, 1, 5, 5, 10, 10);
    queue_pair(1, 0, 0, 20, 20, 1, 5, 5, 10, 10);
    queue_pair(1, 0, 0, 20, 20, 1, -5, -5, 10, 10);
    queue_pair(1, 0, 0, 20, 20, 1, 10, 10, 20, 20);
    queue_pair(1, 0, 0, 20, 20, 1, 8, -5, 30, 30);
    queue_pair(1, 0, 0, 20, 20, 1, -5, 8, 30, 30);
    queue_pair(1, 32760, 0, 20, 10, 1, 32765, 2, 4, 4);
    queue_pair(1, 0, 32767, 5, 5, 1, 0, 32767, 5, 1);
    queue_pair(1, -32768, -32768, 32767, 32767, 1, 10000, 10000, 100, 100);
    queue_pair(1, 32767, 32767, 1, 1, 1, 32767, 32767, 1, 1);
    queue_pair(1, -32768, -32768, 32767, 32767, 1, -32768, -32768, 32767, 32767);
    queue_pair(1, -32768, 0, 32767, 1, 1, -32768, 0, 1, 1);
    queue_pair(1, -1, -1, -1, -1, 1, -1, -1, -1, -1);
    for (int i = 0; i < 450; i++) begin
      r = $urandom_range(0, 99);
      if (r < 22) begin
        queue_pair($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom,
                   $urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom);
      end else begin
        if (r < 30) begin
          ox = 32767 - $urandom_range(0, 60);
          oy = -32768 + $urandom_range(0, 60);
        end else begin
          ox = $urandom_range(0, 65535) - 32768;
          oy = $urandom_range(0, 65535) - 32768;
        end
        queue_pair($urandom_range(0, 31) != 0, ox, oy, pick_size(), pick_size(),
                   $urandom_range(0, 15) != 0,
                   ox + $urandom_range(0, 100) - 40, oy + $urandom_range(0, 100) - 40,
                   pick_size() + $urandom_range(0, 40), pick_size() + $urandom_range(0, 40));
      end
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pair_queue.size() != 0 || s_valid) begin
      @(posedge clk_i);
    end
    while (expected_frags.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
